// ===== hw/rtl/c2p_pkg.sv =====
// Shared types, constants and tables for the cartesian-to-polar converter.
package c2p_pkg;

	localparam int GUARD = 16;
	localparam int ZW = 32;
	localparam int GW = 30;
	localparam int ANGLE_MAX = 23040;
	localparam logic signed [ZW-1:0] QUARTER_TURN = 32'sd377487360;

	typedef struct packed {
		logic signed [15:0] x_coord;
		logic signed [15:0] y_coord;
	} coord_t;

	typedef struct packed {
		logic [15:0]        magnitude;
		logic signed [15:0] angle_deg;
	} polar_t;

	typedef struct packed {
		logic valid;
		logic zero;
	} ctl_t;

	// atan(2^-i) in degrees * 2^22
	function automatic logic signed [ZW-1:0] atan_entry(input int i);
		logic signed [ZW-1:0] v;
		case (i)
			0:  v = 32'sd188743680;
			1:  v = 32'sd111421900;
			2:  v = 32'sd58872272;
			3:  v = 32'sd29884485;
			4:  v = 32'sd15000234;
			5:  v = 32'sd7507429;
			6:  v = 32'sd3754631;
			7:  v = 32'sd1877430;
			8:  v = 32'sd938729;
			9:  v = 32'sd469366;
			10: v = 32'sd234683;
			11: v = 32'sd117342;
			12: v = 32'sd58671;
			13: v = 32'sd29335;
			14: v = 32'sd14668;
			15: v = 32'sd7334;
			16: v = 32'sd3667;
			17: v = 32'sd1833;
			18: v = 32'sd917;
			19: v = 32'sd458;
			20: v = 32'sd229;
			21: v = 32'sd115;
			22: v = 32'sd57;
			23: v = 32'sd29;
			24: v = 32'sd14;
			25: v = 32'sd7;
			26: v = 32'sd4;
			27: v = 32'sd2;
			28: v = 32'sd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// 1/K(n) * 2^30
	function automatic logic [GW-1:0] inv_gain(input int n);
		longint g;
		g = 64'd652032874;
		if (n < 20)
			g = g + ((64'd434688583 + (64'd1 << (2 * n - 1))) >> (2 * n));
		return GW'(g);
	endfunction

endpackage

// ===== hw/rtl/c2p_prerot.sv =====
// Input stage: coordinate capture and pre-rotation into the right half plane.
module c2p_prerot #(
	parameter int CW = 16,
	parameter int DW = 35
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  c2p_pkg::coord_t               coord,
	output c2p_pkg::ctl_t                 ctl_s0,
	output logic signed [DW-1:0]          x_s0,
	output logic signed [DW-1:0]          y_s0,
	output logic signed [c2p_pkg::ZW-1:0] z_s0
);
	import c2p_pkg::*;

	logic signed [CW-1:0] xi, yi;
	logic signed [DW-1:0] xe, ye, xr, yr;
	logic signed [ZW-1:0] zr;

	assign xi = CW'($unsigned(coord.x_coord));
	assign yi = CW'($unsigned(coord.y_coord));
	assign xe = DW'(xi);
	assign ye = DW'(yi);

	always_comb begin
		if (xe < 0) begin
			if (ye >= 0) begin
				xr = ye;
				yr = -xe;
				zr = QUARTER_TURN;
			end else begin
				xr = -ye;
				yr = xe;
				zr = -QUARTER_TURN;
			end
		end else begin
			xr = xe;
			yr = ye;
			zr = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else begin
			ctl_s0.valid <= accept;
			ctl_s0.zero  <= (xi == '0) && (yi == '0);
		end
	end

	always_ff @(posedge clk) begin
		x_s0 <= xr <<< GUARD;
		y_s0 <= yr <<< GUARD;
		z_s0 <= zr;
	end

endmodule

// ===== hw/rtl/c2p_stage.sv =====
// One registered vectoring micro-rotation.
module c2p_stage #(
	parameter int DW = 35,
	parameter int SHIFT = 0
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  c2p_pkg::ctl_t                 ctl_prev,
	input  logic signed [DW-1:0]          x_prev,
	input  logic signed [DW-1:0]          y_prev,
	input  logic signed [c2p_pkg::ZW-1:0] z_prev,
	output c2p_pkg::ctl_t                 ctl_s,
	output logic signed [DW-1:0]          x_s,
	output logic signed [DW-1:0]          y_s,
	output logic signed [c2p_pkg::ZW-1:0] z_s
);
	import c2p_pkg::*;

	localparam logic signed [ZW-1:0] STEP_ANGLE = atan_entry(SHIFT);

	logic signed [DW-1:0] dx, dy;

	assign dx = y_prev >>> SHIFT;
	assign dy = x_prev >>> SHIFT;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s <= '0;
		end else begin
			ctl_s <= ctl_prev;
		end
	end

	always_ff @(posedge clk) begin
		if (y_prev >= 0) begin
			x_s <= x_prev + dx;
			y_s <= y_prev - dy;
			z_s <= z_prev + STEP_ANGLE;
		end else begin
			x_s <= x_prev - dx;
			y_s <= y_prev + dy;
			z_s <= z_prev - STEP_ANGLE;
		end
	end

endmodule

// ===== hw/rtl/c2p_scale.sv =====
// Output stages: gain correction of the magnitude and rounding of the angle.
module c2p_scale #(
	parameter int DW = 35,
	parameter int STAGES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  c2p_pkg::ctl_t                 ctl_prev,
	input  logic signed [DW-1:0]          x_prev,
	input  logic signed [c2p_pkg::ZW-1:0] z_prev,
	output c2p_pkg::ctl_t                 ctl_s2,
	output c2p_pkg::polar_t               polar_s2
);
	import c2p_pkg::*;

	localparam logic [GW-1:0] GAIN = inv_gain(STAGES);
	localparam int HW = DW - 1 - GUARD;
	localparam int PW = HW + GW + 1;
	localparam logic signed [ZW-1:0] HALF_LSB = ZW'(1) << 14;
	localparam logic [PW-1:0] MAG_RND = PW'(1) << 29;

	logic [DW-2:0]              xf;
	logic [GUARD+GW-1:0]        pl_full;
	logic signed [ZW-1:0]       zr, ar;
	logic signed [15:0]         ang;

	logic [HW+GW-1:0]           ph_s1;
	logic [GW-1:0]              pl_s1;
	logic signed [15:0]         angle_s1;
	ctl_t                       ctl_s1;

	logic [PW-1:0]              psum;
	logic [PW-31:0]             magw;

	assign xf = (x_prev < 0) ? '0 : x_prev[DW-2:0];
	assign pl_full = xf[GUARD-1:0] * GAIN;
	assign zr = z_prev + HALF_LSB;
	assign ar = zr >>> 15;

	always_comb begin
		if (ar > ANGLE_MAX)
			ang = 16'(ANGLE_MAX);
		else if (ar < -ANGLE_MAX)
			ang = -16'(ANGLE_MAX);
		else
			ang = 16'(ar);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else begin
			ctl_s1 <= ctl_prev;
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		ph_s1    <= xf[DW-2:GUARD] * GAIN;
		pl_s1    <= pl_full[GUARD+GW-1:GUARD];
		angle_s1 <= ctl_prev.zero ? '0 : ang;
	end

	assign psum = PW'(ph_s1) + PW'(pl_s1) + MAG_RND;
	assign magw = psum[PW-1:30];

	always_ff @(posedge clk) begin
		if (ctl_s1.zero)
			polar_s2.magnitude <= '0;
		else if (magw > 65535)
			polar_s2.magnitude <= 16'hFFFF;
		else
			polar_s2.magnitude <= 16'(magw);
		polar_s2.angle_deg <= angle_s1;
	end

endmodule

// ===== hw/rtl/cartesian_to_polar.sv =====
// Pipelined CORDIC cartesian-to-polar converter, top level.
// Throughput: one vector per clock; pre-rotation, one stage per micro-rotation, two scale stages.
// busy stays low: the result side never stalls the pipeline.
// Reset clears all valid bits asynchronously; data registers are not reset.
module cartesian_to_polar #(
	parameter int COORD_WIDTH = 16,
	parameter int ROTATION_STAGES = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  c2p_pkg::coord_t coord,
	output logic            done,
	output c2p_pkg::polar_t polar
);
	import c2p_pkg::*;

	localparam int DW = COORD_WIDTH + GUARD + 3;

	ctl_t                 ctl_p [0:ROTATION_STAGES];
	logic signed [DW-1:0] x_p   [0:ROTATION_STAGES];
	logic signed [DW-1:0] y_p   [0:ROTATION_STAGES];
	logic signed [ZW-1:0] z_p   [0:ROTATION_STAGES];
	ctl_t                 ctl_out;
	logic                 accept;

	assign busy = 1'b0;
	assign accept = start && !busy;

	c2p_prerot #(
		.CW(COORD_WIDTH),
		.DW(DW)
	) u_prerot (
		.clk(clk),
		.arst_n(arst_n),
		.accept(accept),
		.coord(coord),
		.ctl_s0(ctl_p[0]),
		.x_s0(x_p[0]),
		.y_s0(y_p[0]),
		.z_s0(z_p[0])
	);

	for (genvar i = 0; i < ROTATION_STAGES; i++) begin : g_rot
		c2p_stage #(
			.DW(DW),
			.SHIFT(i)
		) u_stage (
			.clk(clk),
			.arst_n(arst_n),
			.ctl_prev(ctl_p[i]),
			.x_prev(x_p[i]),
			.y_prev(y_p[i]),
			.z_prev(z_p[i]),
			.ctl_s(ctl_p[i+1]),
			.x_s(x_p[i+1]),
			.y_s(y_p[i+1]),
			.z_s(z_p[i+1])
		);
	end

	c2p_scale #(
		.DW(DW),
		.STAGES(ROTATION_STAGES)
	) u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.ctl_prev(ctl_p[ROTATION_STAGES]),
		.x_prev(x_p[ROTATION_STAGES]),
		.z_prev(z_p[ROTATION_STAGES]),
		.ctl_s2(ctl_out),
		.polar_s2(polar)
	);

	assign done = ctl_out.valid;

`ifndef SYNTHESIS
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##(ROTATION_STAGES + 3) done)
		else $error("result beat missing after accepted vector");

	a_no_phantom: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(accept, ROTATION_STAGES + 3))
		else $error("result beat without a matching input");

	a_zero_vec: assert property (@(posedge clk) disable iff (!arst_n)
		accept && coord.x_coord == 16'sd0 && coord.y_coord == 16'sd0
		|-> ##(ROTATION_STAGES + 3) (polar.magnitude == 16'd0 && polar.angle_deg == 16'sd0))
		else $error("zero vector did not give zero result");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (polar.angle_deg <= 16'sd23040 && polar.angle_deg >= -16'sd23040))
		else $error("angle out of range");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cartesian-to-polar converter, with a built-in CORDIC predictor.
module tb;
	import c2p_pkg::*;

	localparam int STAGES = 16;
	localparam int LATENCY = STAGES + 3;
	localparam int SHOWN_MAX = 100;

	// atan(2^-i) in degrees * 2^22
	localparam longint ATAN_DEG22 [32] = '{
		188743680, 111421900, 58872272, 29884485, 15000234, 7507429, 3754631,
		1877430, 938729, 469366, 234683, 117342, 58671, 29335, 14668, 7334,
		3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0, 0
	};

	logic   clk;
	logic   arst_n;
	logic   start;
	logic   busy;
	coord_t coord;
	logic   done;
	polar_t polar;

	polar_t pending_polar[$];
	int     mismatch_count;
	int     sender_idle_pct;

	cartesian_to_polar dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.coord  (coord),
		.done   (done),
		.polar  (polar)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic polar_t polar_of(coord_t c);
		longint x, y, z, dx, dy, ang;
		longint unsigned xf, g, p, mag;
		polar_t r;
		if (c.x_coord == 0 && c.y_coord == 0)
			return '0;
		z = 0;
		if (c.x_coord < 0) begin
			if (c.y_coord >= 0) begin
				x = longint'(c.y_coord);
				y = -longint'(c.x_coord);
				z = longint'(90) <<< 22;
			end else begin
				x = -longint'(c.y_coord);
				y = longint'(c.x_coord);
				z = -(longint'(90) <<< 22);
			end
		end else begin
			x = longint'(c.x_coord);
			y = longint'(c.y_coord);
		end
		x = x <<< GUARD;
		y = y <<< GUARD;
		for (int i = 0; i < STAGES; i++) begin
			dx = y >>> i;
			dy = x >>> i;
			if (y >= 0) begin
				x = x + dx;
				y = y - dy;
				z = z + ATAN_DEG22[i];
			end else begin
				x = x - dx;
				y = y + dy;
				z = z - ATAN_DEG22[i];
			end
		end
		xf = (x < 0) ? 64'd0 : longint'(x);
		g = 64'd652032874;
		if (STAGES < 20)
			g = g + ((64'd434688583 + (64'd1 << (2 * STAGES - 1))) >> (2 * STAGES));
		p = (xf >> 16) * g + (((xf & 64'hFFFF) * g) >> 16);
		mag = (p + (64'd1 << 29)) >> 30;
		if (mag > 64'hFFFF)
			mag = 64'hFFFF;
		ang = (z + (longint'(1) <<< 14)) >>> 15;
		if (ang > ANGLE_MAX)
			ang = ANGLE_MAX;
		if (ang < -ANGLE_MAX)
			ang = -ANGLE_MAX;
		r.magnitude = mag[15:0];
		r.angle_deg = ang[15:0];
		return r;
	endfunction

	task automatic report_mismatch(string what, int got, int want);
		if (mismatch_count < SHOWN_MAX)
			$display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		mismatch_count++;
	endtask

	// result checker
	always @(posedge clk) begin
		polar_t want;
		if (arst_n && done) begin
			if (pending_polar.size() == 0) begin
				report_mismatch("unexpected beat, magnitude", int'(polar.magnitude), 0);
			end else begin
				want = pending_polar.pop_front();
				if (polar.magnitude !== want.magnitude)
					report_mismatch("magnitude", int'(polar.magnitude), int'(want.magnitude));
				if (polar.angle_deg !== want.angle_deg)
					report_mismatch("angle_deg", int'(polar.angle_deg), int'(want.angle_deg));
			end
		end
	end

	// one beat; called at a falling edge, returns at a falling edge
	task automatic send_coord(logic signed [15:0] x, logic signed [15:0] y);
		coord_t c;
		c.x_coord = x;
		c.y_coord = y;
		if ($urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		start <= 1'b1;
		coord <= c;
		forever begin
			@(posedge clk);
			if (!busy)
				break;
		end
		pending_polar.push_back(polar_of(c));
		@(negedge clk);
	endtask

	task automatic wait_empty();
		start <= 1'b0;
		do
			@(negedge clk);
		while (pending_polar.size() != 0);
	endtask

	function automatic logic signed [15:0] edge_value();
		case ($urandom_range(6))
			0: return -16'sd32768;
			1: return -16'sd32767;
			2: return -16'sd1;
			3: return 16'sd0;
			4: return 16'sd1;
			5: return 16'sd32766;
			default: return 16'sd32767;
		endcase
	endfunction

	task automatic send_random_coord();
		logic signed [15:0] x, y;
		case ($urandom_range(5))
			0: begin
				x = $urandom;
				y = $urandom;
			end
			1: begin
				x = $urandom_range(16) - 8;
				y = $urandom_range(16) - 8;
			end
			2: begin
				x = $urandom;
				y = 0;
				if ($urandom_range(1)) begin
					y = x;
					x = 0;
				end
			end
			3: begin
				x = edge_value();
				y = edge_value();
			end
			4: begin
				x = -$urandom_range(32768, 1);
				y = $urandom;
			end
			default: begin
				x = $urandom_range(32767);
				y = $urandom_range(1) ? x : -x;
				if ($urandom_range(1))
					x = -x;
			end
		endcase
		send_coord(x, y);
	endtask

	task automatic test_special_vectors();
		send_coord(0, 0);
		send_coord(1, 0);
		send_coord(0, 1);
		send_coord(-1, 0);
		send_coord(0, -1);
		send_coord(-32768, 0);
		send_coord(-5, 0);
		send_coord(0, -32768);
		send_coord(0, 32767);
		send_coord(32767, 0);
		send_coord(32767, 32767);
		send_coord(-32768, -32768);
		send_coord(32767, -32768);
		send_coord(-32768, 32767);
		send_coord(-32768, -1);
		send_coord(-1, -32768);
		send_coord(-1, -1);
		send_coord(1, -1);
		send_coord(-1, 1);
		send_coord(3, 4);
		send_coord(-16'sd21846, 16'sd21845);
		send_coord(16'sh5555, -16'sh5556);
	endtask

	task automatic test_random_stream(int count, int idle_pct);
		sender_idle_pct = idle_pct;
		repeat (count)
			send_random_coord();
	endtask

	// bursts separated by full drains of the pipeline
	task automatic test_paused_bursts();
		sender_idle_pct = 0;
		repeat (4) begin
			repeat ($urandom_range(5, 15))
				send_random_coord();
			wait_empty();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		coord = '0;
		mismatch_count = 0;
		sender_idle_pct = 0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_special_vectors();
		test_random_stream(220, 17);
		test_random_stream(220, 81);
		test_random_stream(200, 0);
		test_paused_bursts();

		wait_empty();
		repeat (LATENCY + 4) @(negedge clk);
		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
